[rtl/core/rau_pkg.sv]
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types, codes and helpers for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int OPW = 16;
    localparam int RESW = 32;
    localparam int DIVW = 32;
    localparam int DCNTW = $clog2(DIVW + 1);
    localparam int GW = OPW + 1;
    localparam int KW = $clog2(GW + 1);

    typedef enum logic [2:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_MOD = 3'd4,
        CMD_RED = 3'd5,
        CMD_CYC = 3'd6,
        CMD_ABS = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_ZERO_DEN = 2'd1,
        STAT_DIV_ZERO = 2'd2,
        STAT_RSVD     = 2'd3
    } stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_GCD,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_FIN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic            start;
        logic [DIVW-1:0] dividend;
        logic [DIVW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic            done;
        logic [DIVW-1:0] quotient;
        logic [DIVW-1:0] remainder;
    } div_resp_t;

    // clamp a 34-bit signed value into the result range
    function automatic logic signed [RESW-1:0] sat_res(input logic signed [33:0] v);
        logic signed [33:0] hi;
        logic signed [33:0] lo;
        hi = 34'sd2147483647;
        lo = -34'sd2147483648;
        if (v > hi)
            return RESW'(hi);
        else if (v < lo)
            return RESW'(lo);
        else
            return RESW'(v);
    endfunction

endpackage

[rtl/core/rau_if.sv]
// ----------------------------------------------------------------------------
// rau_in_if / rau_out_if
// Valid/ready channels carrying operand and result transactions.
// ----------------------------------------------------------------------------
interface rau_in_if;
    logic                           valid;
    logic                           ready;
    logic [2:0]                     command;
    logic signed [rau_pkg::OPW-1:0] a_numerator;
    logic signed [rau_pkg::OPW-1:0] a_denominator;
    logic signed [rau_pkg::OPW-1:0] b_numerator;
    logic signed [rau_pkg::OPW-1:0] b_denominator;

    modport source (output valid, command, a_numerator, a_denominator,
                    b_numerator, b_denominator, input ready);
    modport sink   (input valid, command, a_numerator, a_denominator,
                    b_numerator, b_denominator, output ready);
endinterface

interface rau_out_if;
    logic                            valid;
    logic                            ready;
    logic signed [rau_pkg::RESW-1:0] res_numerator;
    logic signed [rau_pkg::RESW-1:0] res_denominator;
    logic [1:0]                      status;

    modport source (output valid, res_numerator, res_denominator, status,
                    input ready);
    modport sink   (input valid, res_numerator, res_denominator, status,
                    output ready);
endinterface

[rtl/core/rau_div.sv]
// ----------------------------------------------------------------------------
// rau_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_div (
    input  logic               clk,
    input  logic               rst_n,
    input  rau_pkg::div_req_t  req,
    output rau_pkg::div_resp_t resp
);
    import rau_pkg::*;

    logic [DIVW:0]    rem_reg, rem_next;
    logic [DIVW-1:0]  quo_reg, quo_next;
    logic [DIVW-1:0]  dsr_reg, dsr_next;
    logic [DCNTW-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DIVW:0]    rem_sh;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg[DIVW-1:0], quo_reg[DIVW-1]};
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, dsr_reg})
            begin
                rem_next = rem_sh - {1'b0, dsr_reg};
                quo_next = {quo_reg[DIVW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[DIVW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DCNTW'(DIVW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign resp.done      = done_reg;
    assign resp.quotient  = quo_reg;
    assign resp.remainder = rem_reg[DIVW-1:0];

endmodule

[rtl/core/rational_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Sequenced rational arithmetic on two 16-bit fractions.
// ----------------------------------------------------------------------------
// One transaction at a time; ready is low from acceptance until the result
// is taken. Add/sub/mul/div make three passes through one 16x16 multiplier
// and then finish; mod adds a restoring divide after the multiplies, cycle
// runs one divide, reduce runs a binary GCD (one subtract or shift per
// cycle) and then two divides, and abs goes straight to finish.
// Errors are flagged at acceptance and return in the next cycle with zero fields.
module rational_arithmetic_unit (
    input  logic      clk,
    input  logic      rst_n,
    rau_in_if.sink    in_ch,
    rau_out_if.source out_ch
);
    import rau_pkg::*;

    state_t state_reg, state_next;

    logic [2:0]             cmd_reg, cmd_next;
    logic signed [OPW-1:0]  an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [OPW-1:0]  an_next, ad_next, bn_next, bd_next;
    logic signed [RESW-1:0] p1_reg, p2_reg, p3_reg, p1_next, p2_next, p3_next;
    logic [GW-1:0]          gp_reg, gq_reg, gp_next, gq_next;
    logic [KW-1:0]          k_reg, k_next;
    logic                   phase_reg, phase_next;
    logic [DIVW-1:0]        qa_reg, qa_next;
    logic signed [RESW-1:0] num_reg, den_reg, num_next, den_next;
    logic [1:0]             stat_reg, stat_next;
    logic                   ovalid_reg, ovalid_next;

    div_req_t  dreq;
    div_resp_t dresp;

    logic signed [OPW-1:0]  mul_a, mul_b;
    logic signed [RESW-1:0] mul_p;
    logic [1:0]             in_stat;
    logic                   in_acc, out_acc, gcd_done, mod_neg;
    logic [GW-1:0]          gcd_val, dm;
    logic signed [GW:0]     nn;
    logic signed [GW+1:0]   tt;

    rau_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (dreq),
        .resp (dresp)
    );

    assign in_acc  = in_ch.valid && in_ch.ready;
    assign out_acc = out_ch.valid && out_ch.ready;

    assign mul_p = RESW'(mul_a) * RESW'(mul_b);

    assign gcd_done = (gp_reg == '0) || (gq_reg == '0);
    assign gcd_val  = (gp_reg | gq_reg) << k_reg;
    assign mod_neg  = (an_reg != '0) && (an_reg[OPW-1] != ad_reg[OPW-1]);

    // cycle: nn = an * sign(ad), dm = |ad|, tt = nn + dm - 1
    assign dm = ad_reg[OPW-1] ? GW'(-ad_reg) : GW'(ad_reg);
    assign nn = ad_reg[OPW-1] ? -(GW+1)'(an_reg) : (GW+1)'(an_reg);
    assign tt = (GW+2)'(nn) + (GW+2)'(signed'({1'b0, dm})) - (GW+2)'(1);

    always_comb
    begin
        in_stat = STAT_OK;
        unique case (cmd_t'(in_ch.command))
            CMD_ADD, CMD_SUB, CMD_MUL:
                if (in_ch.a_denominator == '0 || in_ch.b_denominator == '0)
                    in_stat = STAT_ZERO_DEN;
            CMD_DIV, CMD_MOD:
                if (in_ch.a_denominator == '0)
                    in_stat = STAT_ZERO_DEN;
                else if (in_ch.b_numerator == '0)
                    in_stat = STAT_DIV_ZERO;
            CMD_RED, CMD_CYC:
                if (in_ch.a_denominator == '0)
                    in_stat = STAT_ZERO_DEN;
            default:
                in_stat = STAT_OK;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_acc)
                begin
                    if (in_stat != STAT_OK)
                        state_next = ST_OUT;
                    else
                    begin
                        case (cmd_t'(in_ch.command))
                            CMD_RED: state_next = ST_GCD;
                            CMD_CYC: state_next = ST_DIV_START;
                            CMD_ABS: state_next = ST_FIN;
                            default: state_next = ST_MUL0;
                        endcase
                    end
                end
            ST_MUL0:      state_next = ST_MUL1;
            ST_MUL1:      state_next = ST_MUL2;
            ST_MUL2:      state_next = (cmd_reg == CMD_MOD) ? ST_DIV_START : ST_FIN;
            ST_GCD:       if (gcd_done) state_next = ST_DIV_START;
            ST_DIV_START: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
                if (dresp.done)
                    state_next = (cmd_reg == CMD_RED && !phase_reg) ? ST_DIV_START
                                                                     : ST_FIN;
            ST_FIN:       state_next = ST_OUT;
            ST_OUT:       if (out_acc) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer: multiplier operands and divider request
    always_comb
    begin
        mul_a         = an_reg;
        mul_b         = bd_reg;
        dreq.start    = 1'b0;
        dreq.dividend = '0;
        dreq.divisor  = '0;
        unique case (state_reg)
            ST_MUL0:
            begin
                mul_a = an_reg;
                mul_b = (cmd_reg == CMD_MUL) ? bn_reg : bd_reg;
            end
            ST_MUL1:
            begin
                mul_a = ad_reg;
                mul_b = bn_reg;
            end
            ST_MUL2:
            begin
                mul_a = ad_reg;
                mul_b = bd_reg;
            end
            ST_DIV_START:
            begin
                dreq.start = 1'b1;
                case (cmd_t'(cmd_reg))
                    CMD_MOD:
                    begin
                        dreq.dividend = p1_reg[RESW-1] ? DIVW'(-p1_reg) : DIVW'(p1_reg);
                        dreq.divisor  = p2_reg[RESW-1] ? DIVW'(-p2_reg) : DIVW'(p2_reg);
                    end
                    CMD_CYC:
                    begin
                        dreq.dividend = tt[GW+1] ? DIVW'(-tt) : DIVW'(tt);
                        dreq.divisor  = DIVW'({dm, 1'b0});
                    end
                    default:
                    begin
                        if (!phase_reg)
                            dreq.dividend = an_reg[OPW-1] ? DIVW'(-(GW'(an_reg)))
                                                          : DIVW'(an_reg);
                        else
                            dreq.dividend = DIVW'(dm);
                        dreq.divisor = DIVW'(gcd_val);
                    end
                endcase
            end
            default:
            begin
                mul_a = an_reg;
                mul_b = bd_reg;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        logic signed [33:0] n;
        logic signed [33:0] d;
        logic signed [33:0] r;
        logic [DIVW-1:0]    rr;
        logic               flip;

        cmd_next    = cmd_reg;
        an_next     = an_reg;
        ad_next     = ad_reg;
        bn_next     = bn_reg;
        bd_next     = bd_reg;
        p1_next     = p1_reg;
        p2_next     = p2_reg;
        p3_next     = p3_reg;
        gp_next     = gp_reg;
        gq_next     = gq_reg;
        k_next      = k_reg;
        phase_next  = phase_reg;
        qa_next     = qa_reg;
        num_next    = num_reg;
        den_next    = den_reg;
        stat_next   = stat_reg;
        ovalid_next = ovalid_reg;
        n    = '0;
        d    = '0;
        r    = '0;
        rr   = '0;
        flip = 1'b0;

        case (state_reg)
            ST_IDLE:
                if (in_acc)
                begin
                    cmd_next   = in_ch.command;
                    an_next    = in_ch.a_numerator;
                    ad_next    = in_ch.a_denominator;
                    bn_next    = in_ch.b_numerator;
                    bd_next    = in_ch.b_denominator;
                    gp_next    = in_ch.a_numerator[OPW-1] ? GW'(-in_ch.a_numerator)
                                                          : GW'(in_ch.a_numerator);
                    gq_next    = in_ch.a_denominator[OPW-1] ? GW'(-in_ch.a_denominator)
                                                            : GW'(in_ch.a_denominator);
                    k_next     = '0;
                    phase_next = 1'b0;
                    stat_next  = in_stat;
                    if (in_stat != STAT_OK)
                    begin
                        num_next    = '0;
                        den_next    = '0;
                        ovalid_next = 1'b1;
                    end
                end
            ST_MUL0: p1_next = mul_p;
            ST_MUL1: p2_next = mul_p;
            ST_MUL2: p3_next = mul_p;
            ST_GCD:
                if (!gcd_done)
                begin
                    if (!gp_reg[0] && !gq_reg[0])
                    begin
                        gp_next = gp_reg >> 1;
                        gq_next = gq_reg >> 1;
                        k_next  = k_reg + 1'b1;
                    end
                    else if (!gp_reg[0])
                        gp_next = gp_reg >> 1;
                    else if (!gq_reg[0])
                        gq_next = gq_reg >> 1;
                    else if (gp_reg >= gq_reg)
                        gp_next = gp_reg - gq_reg;
                    else
                        gq_next = gq_reg - gp_reg;
                end
            ST_DIV_WAIT:
                if (dresp.done && !phase_reg)
                begin
                    qa_next    = dresp.quotient;
                    phase_next = 1'b1;
                end
            ST_FIN:
            begin
                case (cmd_t'(cmd_reg))
                    CMD_ADD:
                    begin
                        n = 34'(p1_reg) + 34'(p2_reg);
                        d = 34'(p3_reg);
                        flip = 1'b1;
                    end
                    CMD_SUB:
                    begin
                        n = 34'(p1_reg) - 34'(p2_reg);
                        d = 34'(p3_reg);
                        flip = 1'b1;
                    end
                    CMD_MUL:
                    begin
                        n = 34'(p1_reg);
                        d = 34'(p3_reg);
                        flip = 1'b1;
                    end
                    CMD_DIV:
                    begin
                        n = 34'(p1_reg);
                        d = 34'(p2_reg);
                        flip = 1'b1;
                    end
                    CMD_MOD:
                    begin
                        r = signed'({2'b00, dresp.remainder});
                        n = (mod_neg != p1_reg[RESW-1]) ? -r : r;
                        d = mod_neg ? -34'(p3_reg) : 34'(p3_reg);
                    end
                    CMD_RED:
                    begin
                        n = signed'({2'b00, qa_reg});
                        if (an_reg[OPW-1])
                            n = -n;
                        d = signed'({2'b00, dresp.quotient});
                        if (ad_reg[OPW-1])
                            d = -d;
                        flip = 1'b1;
                    end
                    CMD_CYC:
                    begin
                        if (nn == -(GW+1)'(signed'({1'b0, dm})))
                        begin
                            n = 34'(signed'({1'b0, dm}));
                            d = n;
                        end
                        else
                        begin
                            rr = dresp.remainder;
                            if (tt[GW+1] && rr != '0)
                                rr = DIVW'({dm, 1'b0}) - rr;
                            r = signed'({2'b00, rr}) - 34'(signed'({1'b0, dm})) + 34'sd1;
                            n = ad_reg[OPW-1] ? -r : r;
                            d = 34'(ad_reg);
                        end
                    end
                    default:
                    begin
                        n = an_reg[OPW-1] ? -34'(an_reg) : 34'(an_reg);
                        d = ad_reg[OPW-1] ? -34'(ad_reg) : 34'(ad_reg);
                    end
                endcase
                if (flip && d < 0)
                begin
                    n = -n;
                    d = -d;
                end
                num_next    = sat_res(n);
                den_next    = sat_res(d);
                ovalid_next = 1'b1;
            end
            ST_OUT:
                if (out_acc)
                    ovalid_next = 1'b0;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
            phase_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            phase_reg  <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        an_reg   <= an_next;
        ad_reg   <= ad_next;
        bn_reg   <= bn_next;
        bd_reg   <= bd_next;
        p1_reg   <= p1_next;
        p2_reg   <= p2_next;
        p3_reg   <= p3_next;
        gp_reg   <= gp_next;
        gq_reg   <= gq_next;
        k_reg    <= k_next;
        qa_reg   <= qa_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        stat_reg <= stat_next;
    end

    assign in_ch.ready            = (state_reg == ST_IDLE);
    assign out_ch.valid           = ovalid_reg;
    assign out_ch.res_numerator   = num_reg;
    assign out_ch.res_denominator = den_reg;
    assign out_ch.status          = stat_reg;

    a_valid_in_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> state_reg == ST_OUT)
        else $error("result valid outside output state");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.status != STAT_OK) |->
            (out_ch.res_numerator == '0 && out_ch.res_denominator == '0))
        else $error("error result carries nonzero fields");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ch.ready)
        else $error("accepted a transaction while busy");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        dresp.done |-> state_reg == ST_DIV_WAIT)
        else $error("divider finished outside wait state");

endmodule
